// ===== rtl/fdtw_pkg.sv =====
// ----------------------------------------------------------------------------
// fdtw_pkg
// Shared types and codes of the devicetree structure token walker.
// ----------------------------------------------------------------------------
package fdtw_pkg;

  localparam int WORD_W       = 32;
  localparam int WORDS_LEFT_W = 30;
  localparam int STATUS_W     = 2;
  localparam int NODE_DEPTH_W = 5;

  // Structure block tokens
  localparam logic [WORD_W-1:0] TOK_BEGIN_NODE = 32'h0000_0001;
  localparam logic [WORD_W-1:0] TOK_END_NODE   = 32'h0000_0002;
  localparam logic [WORD_W-1:0] TOK_PROP       = 32'h0000_0003;
  localparam logic [WORD_W-1:0] TOK_NOP        = 32'h0000_0004;
  localparam logic [WORD_W-1:0] TOK_END        = 32'h0000_0009;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PARSING = 2'd0;
  localparam logic [STATUS_W-1:0] ST_END     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

  // Register map: one register, indexed by paddr[2]
  localparam int          APB_ADDR_W     = 3;
  localparam logic        REG_TARGET_IDX = 1'b0;

  localparam logic [WORDS_LEFT_W-1:0] WORDS_MAX = '1;

  typedef enum logic [5:0] {
    PH_DONE         = 6'b000001,
    PH_TOKEN        = 6'b000010,
    PH_NODE_NAME    = 6'b000100,
    PH_PROP_LEN     = 6'b001000,
    PH_PROP_NAMEOFF = 6'b010000,
    PH_PROP_VALUE   = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t                  phase;
    logic [WORDS_LEFT_W-1:0] words_left;
    logic                    name_match;
    logic                    first_pending;
    logic [WORD_W-1:0]       captured;
  } walk_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
  } step_flags_t;

endpackage

// ===== rtl/fdtw_in_if.sv =====
// ----------------------------------------------------------------------------
// fdtw_in_if
// Structure word channel: valid/ready handshake with word and start flag.
// ----------------------------------------------------------------------------
interface fdtw_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        start_req;

  modport source (output valid, output word, output start_req, input ready);
  modport sink   (input valid, input word, input start_req, output ready);
endinterface

// ===== rtl/fdtw_out_if.sv =====
// ----------------------------------------------------------------------------
// fdtw_out_if
// Result channel: valid/ready handshake with status, match and depth.
// ----------------------------------------------------------------------------
interface fdtw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [31:0] found_value;
  logic [4:0]  node_depth;

  modport source (output valid, output status, output found, output found_value,
                  output node_depth, input ready);
  modport sink   (input valid, input status, input found, input found_value,
                  input node_depth, output ready);
endinterface

// ===== rtl/fdtw_apb_regs.sv =====
// ----------------------------------------------------------------------------
// fdtw_apb_regs
// APB register file holding the target property name offset.
// ----------------------------------------------------------------------------
module fdtw_apb_regs
  import fdtw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [WORD_W-1:0]     target_name_offset
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TARGET_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_name_offset <= '0;
    end else if (wr_en) begin
      target_name_offset <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TARGET_IDX: prdata = target_name_offset;
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/fdtw_step.sv =====
// ----------------------------------------------------------------------------
// fdtw_step
// Next-state and result logic for one structure word.
// ----------------------------------------------------------------------------
module fdtw_step
  import fdtw_pkg::*;
#(
  parameter int MAX_DEPTH = 16,
  parameter int DEPTH_W   = 5
) (
  input  walk_state_t        st,
  input  logic [DEPTH_W-1:0] nest,
  input  logic [WORD_W-1:0]  word,
  input  logic               start_req,
  input  logic [WORD_W-1:0]  target,
  output walk_state_t        st_next,
  output logic [DEPTH_W-1:0] nest_next,
  output step_flags_t        flags
);

  walk_state_t        cur;
  logic [DEPTH_W-1:0] nest_cur;
  logic [30:0]        words_raw;
  logic               zero_byte;

  // Padded word count of the property value, (len + 3) / 4
  assign words_raw = {1'b0, word[31:2]} + 31'(word[1:0] != 2'b00);
  assign zero_byte = (word[31:24] == 8'h00) || (word[23:16] == 8'h00) ||
                     (word[15:8] == 8'h00)  || (word[7:0] == 8'h00);

  always_comb begin
    cur      = st;
    nest_cur = nest;
    // A start request aborts whatever was in progress; the capture is kept
    if (start_req) begin
      cur.phase         = PH_TOKEN;
      cur.words_left    = '0;
      cur.name_match    = 1'b0;
      cur.first_pending = 1'b0;
      nest_cur          = '0;
    end

    st_next      = cur;
    nest_next    = nest_cur;
    flags.status = ST_PARSING;
    flags.found  = 1'b0;

    unique case (cur.phase)
      PH_TOKEN: begin
        unique case (word)
          TOK_BEGIN_NODE: begin
            if (nest_cur < DEPTH_W'(MAX_DEPTH)) nest_next = nest_cur + 1'b1;
            st_next.phase = PH_NODE_NAME;
          end
          TOK_END_NODE: begin
            if (nest_cur != '0) nest_next = nest_cur - 1'b1;
          end
          TOK_PROP: st_next.phase = PH_PROP_LEN;
          TOK_NOP:  ;
          TOK_END: begin
            st_next.phase = PH_DONE;
            flags.status  = ST_END;
          end
          default: begin
            st_next.phase = PH_DONE;
            flags.status  = ST_INVALID;
          end
        endcase
      end
      PH_NODE_NAME: begin
        if (zero_byte) st_next.phase = PH_TOKEN;
      end
      PH_PROP_LEN: begin
        st_next.words_left    = words_raw[30] ? WORDS_MAX : words_raw[29:0];
        st_next.first_pending = (word >= 32'd4);
        st_next.phase         = PH_PROP_NAMEOFF;
      end
      PH_PROP_NAMEOFF: begin
        st_next.name_match = (word == target);
        st_next.phase      = (cur.words_left == '0) ? PH_TOKEN : PH_PROP_VALUE;
      end
      PH_PROP_VALUE: begin
        if (cur.first_pending && cur.name_match) begin
          st_next.captured = word;
          flags.found      = 1'b1;
        end
        st_next.first_pending = 1'b0;
        if (cur.words_left != '0) st_next.words_left = cur.words_left - 1'b1;
        if (cur.words_left <= 30'd1) st_next.phase = PH_TOKEN;
      end
      default: begin
        flags.status = ST_IGNORED;
      end
    endcase
  end

endmodule

// ===== rtl/fdt_struct_token_walker.sv =====
// ----------------------------------------------------------------------------
// fdt_struct_token_walker
// Flattened devicetree structure block walker with property value capture.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one big-endian structure word per transaction; start_req marks
//            the first token word of a new block and restarts the walk.
//   result : one transaction per accepted word carrying status, found, the
//            last captured value and the node depth after that word.
//   APB    : target_name_offset at byte address 0; write only while idle.
// The result is registered: a word accepted at an edge has its result valid
// after that edge. Throughput is one word per cycle while results are taken,
// set by the single result register; a new word is taken while the held
// result is being taken in the same cycle.
// When the receiver stalls, hold the result and stop accepting words until
// it is taken. Reset clears the walk to "finished", so words are reported as
// ignored until a start request, and clears the captured value and depth.
// ----------------------------------------------------------------------------
module fdt_struct_token_walker
  import fdtw_pkg::*;
#(
  parameter int MAX_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  fdtw_in_if.sink               item,
  fdtw_out_if.source            result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  logic [WORD_W-1:0]  target_name_offset;
  walk_state_t        st;
  walk_state_t        st_next;
  logic [DEPTH_W-1:0] nest;
  logic [DEPTH_W-1:0] nest_next;
  step_flags_t        flags;
  logic               accept;

  // Configuration register
  fdtw_apb_regs u_regs (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .target_name_offset (target_name_offset)
  );

  // Per-word decode of token phase, depth and capture
  fdtw_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .DEPTH_W   (DEPTH_W)
  ) u_step (
    .st        (st),
    .nest      (nest),
    .word      (item.word),
    .start_req (item.start_req),
    .target    (target_name_offset),
    .st_next   (st_next),
    .nest_next (nest_next),
    .flags     (flags)
  );

  // Take a word whenever the result register is empty or being drained
  assign item.ready = !result.valid || result.ready;
  assign accept     = item.valid && item.ready;

  // Walk state: advance once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_DONE;
      st.words_left    <= '0;
      st.name_match    <= 1'b0;
      st.first_pending <= 1'b0;
      st.captured      <= '0;
      nest             <= '0;
    end else if (accept) begin
      st   <= st_next;
      nest <= nest_next;
    end
  end

  // Result register: valid is control, payload loads with each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.status      <= flags.status;
      result.found       <= flags.found;
      result.found_value <= st_next.captured;
      result.node_depth  <= NODE_DEPTH_W'(nest_next);
    end
  end

endmodule
